// File: src/jfpi_pkg.sv
package jfpi_pkg;

    localparam int JOINTS_DEF = 7;
    localparam int WRENCH_DIM = 6;
    localparam int SMOOTH_ITEMS = WRENCH_DIM + 2;
    localparam int MUL_W = 33;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_SET = 2'd2;

    localparam logic [2:0] CFG_PERIOD = 3'd0;
    localparam logic [2:0] CFG_PROP_GAIN = 3'd1;
    localparam logic [2:0] CFG_INT_GAIN = 3'd2;
    localparam logic [2:0] CFG_SMOOTHING = 3'd3;
    localparam logic [2:0] CFG_RATE_LIMIT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JAC,
        S_TAU,
        S_ERR,
        S_INT_MUL,
        S_INT,
        S_I_MUL,
        S_CMD,
        S_LIM,
        S_OUT,
        S_SM
    } state_t;

endpackage

// File: src/jfpi_mul.sv
module jfpi_mul (
    input  logic                                   clk,
    input  logic signed [jfpi_pkg::MUL_W-1:0]      a,
    input  logic signed [jfpi_pkg::MUL_W-1:0]      b,
    output logic signed [2*jfpi_pkg::MUL_W-1:0]    p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

// File: src/joint_force_pi_controller.sv
// A start or set-target request is absorbed while idle; an update request
// steps through S_JAC, S_TAU, S_ERR, S_INT_MUL, S_INT, S_I_MUL, S_CMD, S_LIM
// and S_OUT, which waits while the output is stalled. No request is taken
// until idle again; the last joint also runs the eight-step target smoothing;
// all products share one multiplier. Reset: asynchronous, active low; clears
// stores, gains, configuration and state; datapath registers are not reset.
module joint_force_pi_controller #(
    parameter int JOINTS = jfpi_pkg::JOINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [2:0]         index,
    input  logic signed [31:0] jac_fx,
    input  logic signed [31:0] jac_fy,
    input  logic signed [31:0] jac_fz,
    input  logic signed [31:0] jac_tx,
    input  logic signed [31:0] jac_ty,
    input  logic signed [31:0] jac_tz,
    input  logic signed [31:0] measured_torque,
    input  logic signed [31:0] gravity_torque,
    input  logic signed [31:0] prior_command,
    input  logic signed [31:0] target_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         joint_number,
    output logic signed [31:0] command_torque,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int WD = jfpi_pkg::WRENCH_DIM;
    localparam int MW = jfpi_pkg::MUL_W;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -52'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    jfpi_pkg::state_t state_reg, state_next;
    logic [3:0] k_reg, k_next;

    logic [24:0] period_reg;
    logic [23:0] tprop_reg, tint_reg, pgain_reg, igain_reg;
    logic [16:0] smooth_reg;
    logic [30:0] rlim_reg;

    logic signed [31:0] bias_reg [JOINTS];
    logic signed [31:0] istore_reg [JOINTS];
    logic signed [31:0] target_reg [WD];
    logic signed [31:0] desired_reg [WD];

    logic [2:0] idx_reg;
    logic signed [31:0] jac_reg [WD];
    logic signed [31:0] meas_reg, grav_reg, prior_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] taud_reg, text_reg, err_reg, integ_reg;
    logic signed [43:0] cmd_reg;
    logic signed [44:0] diff_reg;
    logic        out_valid_reg;
    logic [2:0]  joint_reg;
    logic signed [31:0] cmdout_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod;

    logic accept, out_free, upd_ok, start_ok, set_ok;
    logic [JW-1:0] jsel, jin;
    logic [2:0] wsel, wprev;
    logic [3:0] kprev;
    logic [16:0] w_eff;
    logic signed [32:0] cur_a, tgt_a, cur_b;
    logic signed [32:0] sm_new;
    logic signed [42:0] integ_sum;
    logic signed [31:0] integ_new;
    logic signed [44:0] lim_pos, d_raw;

    jfpi_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign upd_ok   = (action == jfpi_pkg::ACT_UPDATE) && (32'(index) < JOINTS);
    assign start_ok = (action == jfpi_pkg::ACT_START) && (32'(index) < JOINTS);
    assign set_ok   = (action == jfpi_pkg::ACT_SET) && (32'(index) < WD);
    assign jsel     = JW'(idx_reg);
    assign jin      = JW'(index);
    assign wsel     = (k_reg < 4'(WD)) ? k_reg[2:0] : 3'd0;
    assign kprev    = k_reg - 4'd1;
    assign wprev    = (kprev < 4'(WD)) ? kprev[2:0] : 3'd0;
    assign w_eff    = (smooth_reg > jfpi_pkg::ONE_Q16) ? jfpi_pkg::ONE_Q16 : smooth_reg;

    assign in_stall       = (state_reg != jfpi_pkg::S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign joint_number   = joint_reg;
    assign command_torque = cmdout_reg;

    always_comb
    begin
        if (k_reg < 4'(WD))
        begin
            cur_a = 33'(desired_reg[wsel]);
            tgt_a = 33'(target_reg[wsel]);
        end
        else if (k_reg == 4'(WD))
        begin
            cur_a = {9'd0, pgain_reg};
            tgt_a = {9'd0, tprop_reg};
        end
        else
        begin
            cur_a = {9'd0, igain_reg};
            tgt_a = {9'd0, tint_reg};
        end
        if (kprev < 4'(WD))
            cur_b = 33'(desired_reg[wprev]);
        else if (kprev == 4'(WD))
            cur_b = {9'd0, pgain_reg};
        else
            cur_b = {9'd0, igain_reg};
        sm_new = cur_b + 33'(prod[48:16]);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            jfpi_pkg::S_JAC:
            begin
                mul_a = 33'(jac_reg[wsel]);
                mul_b = 33'(desired_reg[wsel]);
            end
            jfpi_pkg::S_INT_MUL:
            begin
                mul_a = 33'(err_reg);
                mul_b = {8'd0, period_reg};
            end
            jfpi_pkg::S_INT:
            begin
                mul_a = 33'(err_reg);
                mul_b = {9'd0, pgain_reg};
            end
            jfpi_pkg::S_I_MUL:
            begin
                mul_a = 33'(integ_reg);
                mul_b = {9'd0, igain_reg};
            end
            jfpi_pkg::S_SM:
            begin
                mul_a = tgt_a - cur_a;
                mul_b = {16'd0, w_eff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        integ_sum = 43'(istore_reg[jsel]) + 43'($signed(prod[65:24]));
        integ_new = sat32(52'(integ_sum));
        lim_pos   = {14'd0, rlim_reg};
        d_raw     = 45'(cmd_reg) - 45'(prior_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            jfpi_pkg::S_IDLE:
            begin
                k_next = 4'd0;
                if (accept && upd_ok)
                    state_next = jfpi_pkg::S_JAC;
            end
            jfpi_pkg::S_JAC:
            begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'(WD))
                begin
                    k_next     = 4'd0;
                    state_next = jfpi_pkg::S_TAU;
                end
            end
            jfpi_pkg::S_TAU:     state_next = jfpi_pkg::S_ERR;
            jfpi_pkg::S_ERR:     state_next = jfpi_pkg::S_INT_MUL;
            jfpi_pkg::S_INT_MUL: state_next = jfpi_pkg::S_INT;
            jfpi_pkg::S_INT:     state_next = jfpi_pkg::S_I_MUL;
            jfpi_pkg::S_I_MUL:   state_next = jfpi_pkg::S_CMD;
            jfpi_pkg::S_CMD:     state_next = jfpi_pkg::S_LIM;
            jfpi_pkg::S_LIM:     state_next = jfpi_pkg::S_OUT;
            jfpi_pkg::S_OUT:
            begin
                k_next = 4'd0;
                if (out_free)
                begin
                    if (32'(idx_reg) == JOINTS - 1)
                        state_next = jfpi_pkg::S_SM;
                    else
                        state_next = jfpi_pkg::S_IDLE;
                end
            end
            jfpi_pkg::S_SM:
            begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'(jfpi_pkg::SMOOTH_ITEMS))
                begin
                    k_next     = 4'd0;
                    state_next = jfpi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = jfpi_pkg::S_IDLE;
                k_next     = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jfpi_pkg::S_IDLE;
            k_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 25'd16777;
            tprop_reg  <= '0;
            tint_reg   <= '0;
            smooth_reg <= 17'd65;
            rlim_reg   <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jfpi_pkg::CFG_PERIOD:     period_reg <= cfg_data[24:0];
                jfpi_pkg::CFG_PROP_GAIN:  tprop_reg  <= cfg_data[23:0];
                jfpi_pkg::CFG_INT_GAIN:   tint_reg   <= cfg_data[23:0];
                jfpi_pkg::CFG_SMOOTHING:  smooth_reg <= cfg_data[16:0];
                jfpi_pkg::CFG_RATE_LIMIT: rlim_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
            begin
                bias_reg[i]   <= '0;
                istore_reg[i] <= '0;
            end
            for (int i = 0; i < WD; i++)
            begin
                target_reg[i]  <= '0;
                desired_reg[i] <= '0;
            end
            pgain_reg <= '0;
            igain_reg <= '0;
        end
        else
        begin
            if (accept && set_ok)
                target_reg[index] <= target_value;
            if (accept && start_ok)
            begin
                bias_reg[jin]   <= sat32(52'(measured_torque) - 52'(gravity_torque));
                istore_reg[jin] <= '0;
            end
            if (state_reg == jfpi_pkg::S_INT)
                istore_reg[jsel] <= integ_new;
            if (state_reg == jfpi_pkg::S_SM && k_reg != 4'd0)
            begin
                if (kprev < 4'(WD))
                    desired_reg[wprev] <= sm_new[31:0];
                else if (kprev == 4'(WD))
                    pgain_reg <= sm_new[23:0];
                else
                    igain_reg <= sm_new[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && upd_ok)
        begin
            idx_reg    <= index;
            jac_reg[0] <= jac_fx;
            jac_reg[1] <= jac_fy;
            jac_reg[2] <= jac_fz;
            jac_reg[3] <= jac_tx;
            jac_reg[4] <= jac_ty;
            jac_reg[5] <= jac_tz;
            meas_reg   <= measured_torque;
            grav_reg   <= gravity_torque;
            prior_reg  <= prior_command;
        end
        case (state_reg)
            jfpi_pkg::S_JAC:
            begin
                if (k_reg == 4'd0)
                    acc_reg <= '0;
                else
                    acc_reg <= acc_reg + 52'($signed(prod[63:16]));
            end
            jfpi_pkg::S_TAU:
            begin
                taud_reg <= sat32(acc_reg);
                text_reg <= sat32(52'(meas_reg) - 52'(grav_reg) - 52'(bias_reg[jsel]));
            end
            jfpi_pkg::S_ERR:
                err_reg <= sat32(52'(taud_reg) - 52'(text_reg));
            jfpi_pkg::S_INT:
                integ_reg <= integ_new;
            jfpi_pkg::S_I_MUL:
                cmd_reg <= 44'(taud_reg) + 44'(prod[59:16]);
            jfpi_pkg::S_CMD:
                cmd_reg <= cmd_reg + 44'(prod[59:16]);
            jfpi_pkg::S_LIM:
            begin
                if (d_raw > lim_pos)
                    diff_reg <= lim_pos;
                else if (d_raw < -lim_pos)
                    diff_reg <= -lim_pos;
                else
                    diff_reg <= d_raw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == jfpi_pkg::S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == jfpi_pkg::S_OUT && out_free)
        begin
            joint_reg  <= idx_reg;
            cmdout_reg <= sat32(52'(prior_reg) + 52'(diff_reg));
        end
    end

    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == jfpi_pkg::ACT_UPDATE && 32'(index) < JOINTS
        |=> in_stall)
        else $error("update request did not start the sequencer");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == jfpi_pkg::S_OUT))
        else $error("result appeared outside the output step");

    a_smooth_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == jfpi_pkg::S_SM |-> k_reg <= 4'(jfpi_pkg::SMOOTH_ITEMS))
        else $error("smoothing step count out of range");

endmodule
